// ----- sv/lppr_pkg.sv -----
// Shared constants and types for the lossless pixel predictor and residual block.
package lppr_pkg;

    // Geometry defaults and limits
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int CHANNELS      = 3;
    localparam int ROW_LIMIT     = 4096;
    localparam int ROW_W         = 12;
    localparam int DIM_W         = 13;

    // Word layout
    localparam int SAMPLE_W  = 8;
    localparam int RESID_W   = 9;
    localparam int PIX_BITS  = CHANNELS * SAMPLE_W;
    localparam int RES_BITS  = CHANNELS * RESID_W;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PRED_SEL = 2'd0;
    localparam t_cfg_idx CFG_DECODE   = 2'd1;
    localparam t_cfg_idx CFG_WIDTH    = 2'd2;
    localparam t_cfg_idx CFG_HEIGHT   = 2'd3;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;

    // Predictor codes
    typedef logic [2:0] t_pred_sel;
    localparam t_pred_sel PRED_MED    = 3'd0;
    localparam t_pred_sel PRED_LEFT   = 3'd1;
    localparam t_pred_sel PRED_TOP    = 3'd2;
    localparam t_pred_sel PRED_TLEFT  = 3'd3;
    localparam t_pred_sel PRED_PLANAR = 3'd4;
    localparam t_pred_sel PRED_LHALF  = 3'd5;
    localparam t_pred_sel PRED_THALF  = 3'd6;
    localparam t_pred_sel PRED_AVG    = 3'd7;

endpackage

// ----- sv/lppr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lppr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/lossless_pixel_predictor_residual.sv -----
// Top level of the lossless pixel predictor and residual block.
//
// Takes one three-channel pixel per clock in raster order and returns one word per pixel
// with the prediction, the residual and the pixel itself (original when encoding, rebuilt
// when decoding); tlast marks the last pixel of the frame. The output register is loaded
// as the word is accepted, and a new word is taken every cycle while the output side
// takes words. That rate is set by the left-neighbour loop: the rebuilt pixel of one
// word is the left neighbour of the next, so predict and rebuild close in the same cycle.
// The previous row lives in one RAM of MAX_WIDTH entries with a registered read; it is
// read one column ahead and a write to the column being fetched is forwarded. The row
// store is not cleared after reset; the first row of a frame never reads it. Write the
// configuration only while no word is in flight.
module lossless_pixel_predictor_residual #(
    parameter int MAX_WIDTH = lppr_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lppr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lppr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: pixel_ch0, pixel_ch1, pixel_ch2, resid_in_ch0, resid_in_ch1, resid_in_ch2
    input  logic [lppr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: pred_ch0..2, resid_out_ch0..2, recon_ch0..2
    output logic [lppr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);

    import lppr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int PAD_W = OUT_DATA_W - 2 * PIX_BITS - RES_BITS;

    // Configuration registers
    t_pred_sel           r_pred_sel;
    logic                r_decode;
    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;

    // Position and neighbour state
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [PIX_BITS-1:0] r_left;
    logic [PIX_BITS-1:0] r_upleft;

    // Row store forwarding
    logic                r_fwd;
    logic [PIX_BITS-1:0] r_fwd_data;
    logic [PIX_BITS-1:0] ram_q;
    logic [PIX_BITS-1:0] top_word;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic                in_acc;
    logic                has_left, has_top;
    logic                row_end, frame_end;
    logic [CMP_W-1:0]    col_next_ext;
    logic [DIM_W-1:0]    row_next_ext;
    logic [PIX_BITS-1:0] top_m, pred_w, recon_w;
    logic [RES_BITS-1:0] resid_w;

    function automatic logic [SAMPLE_W-1:0] f_predict(
        input t_pred_sel             sel,
        input logic [SAMPLE_W-1:0]   l,
        input logic [SAMPLE_W-1:0]   t,
        input logic [SAMPLE_W-1:0]   tl
    );
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] planar;
        logic [SAMPLE_W:0]   dt;
        logic [SAMPLE_W:0]   dl;
        logic [SAMPLE_W:0]   dt_r;
        logic [SAMPLE_W:0]   dl_r;
        logic [SAMPLE_W:0]   lt;
        logic [SAMPLE_W-1:0] p;
        hi     = (l > t) ? l : t;
        lo     = (l > t) ? t : l;
        planar = l + t - tl;
        // Signed differences, halved toward zero by rounding negatives up first
        dt     = {1'b0, t} - {1'b0, tl};
        dl     = {1'b0, l} - {1'b0, tl};
        dt_r   = dt + {{SAMPLE_W{1'b0}}, dt[SAMPLE_W]};
        dl_r   = dl + {{SAMPLE_W{1'b0}}, dl[SAMPLE_W]};
        lt     = {1'b0, l} + {1'b0, t};
        case (sel)
            PRED_MED: begin
                if (tl >= hi) begin
                    p = lo;
                end else if (tl <= lo) begin
                    p = hi;
                end else begin
                    p = planar;
                end
            end
            PRED_LEFT:   p = l;
            PRED_TOP:    p = t;
            PRED_TLEFT:  p = tl;
            PRED_PLANAR: p = planar;
            PRED_LHALF:  p = l + dt_r[SAMPLE_W:1];
            PRED_THALF:  p = t + dl_r[SAMPLE_W:1];
            default:     p = lt[SAMPLE_W:1];
        endcase
        return p;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign in_acc      = i_s_tvalid && o_s_tready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred_sel <= PRED_MED;
            r_decode   <= 1'b0;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRED_SEL: r_pred_sel <= t_pred_sel'(i_cfg_data[2:0]);
                CFG_DECODE:   r_decode   <= i_cfg_data[0];
                CFG_WIDTH:    r_width    <= i_cfg_data;
                CFG_HEIGHT:   r_height   <= i_cfg_data;
                default:      r_decode   <= r_decode;
            endcase
        end
    end

    // Row and frame end; width and height are clamped to their limits
    assign has_left     = (r_col != '0);
    assign has_top      = (r_row != '0);
    assign col_next_ext = CMP_W'(r_col) + CMP_W'(1);
    assign row_next_ext = DIM_W'(r_row) + DIM_W'(1);
    assign row_end      = (col_next_ext >= CMP_W'(r_width)) ||
                          (r_col == COL_W'(MAX_WIDTH - 1));
    assign frame_end    = row_end && ((row_next_ext >= r_height) ||
                          (r_row == ROW_W'(ROW_LIMIT - 1)));

    // Advance position on each accepted word
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_upleft <= '0;
            r_fwd    <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_acc) begin
                r_left   <= recon_w;
                r_upleft <= top_m;
            end
            // Forward a write that lands on the column being fetched
            r_fwd <= in_acc && (n_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= recon_w;
    end

    // Previous-row store, fetched one column ahead
    lppr_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_col),
        .i_wr_data (recon_w),
        .i_rd_addr (n_col),
        .o_rd_data (ram_q)
    );

    assign top_word = r_fwd ? r_fwd_data : ram_q;

    // Per-channel prediction, residual and rebuild
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic [SAMPLE_W-1:0] l_v, t_v, tl_v, pred, pix, recon;
        logic [RESID_W-1:0]  rin, rout;

        assign l_v  = has_left ? r_left[SAMPLE_W*c +: SAMPLE_W] : '0;
        assign t_v  = has_top ? top_word[SAMPLE_W*c +: SAMPLE_W] : '0;
        assign tl_v = (has_left && has_top) ? r_upleft[SAMPLE_W*c +: SAMPLE_W] : '0;
        assign pred = f_predict(r_pred_sel, l_v, t_v, tl_v);
        assign pix  = i_s_tdata[SAMPLE_W*c +: SAMPLE_W];
        assign rin  = i_s_tdata[PIX_BITS + RESID_W*c +: RESID_W];

        assign recon = r_decode ? pred - rin[SAMPLE_W-1:0] : pix;
        assign rout  = r_decode ? rin : {1'b0, pred} - {1'b0, pix};

        assign top_m[SAMPLE_W*c +: SAMPLE_W]   = t_v;
        assign pred_w[SAMPLE_W*c +: SAMPLE_W]  = pred;
        assign recon_w[SAMPLE_W*c +: SAMPLE_W] = recon;
        assign resid_w[RESID_W*c +: RESID_W]   = rout;
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= {{PAD_W{1'b0}}, recon_w, resid_w, pred_w};
            r_out_last <= frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- sv/lppr_checker.sv -----
// Port-level checks for the lossless pixel predictor and residual block.
module lppr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [lppr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                             o_m_tlast
);

    // A word shows up at the output the cycle after it is taken
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted word did not reach the output register");

    // An empty output register never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");

    // Nothing is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output word changed");

endmodule

bind lossless_pixel_predictor_residual lppr_checker u_lppr_checker (.*);
